// ===== src/assert_macros.svh =====
// Assertion helpers for the checker file.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/bsb_pkg.sv =====
`default_nettype none

package bsb_pkg;

  // Character forms of the syllable grammar
  typedef enum logic [3:0] {
    FORM_INVALID = 4'd0,
    FORM_CONS    = 4'd1,
    FORM_NUKTA   = 4'd2,
    FORM_HALANT  = 4'd3,
    FORM_MATRA   = 4'd4,
    FORM_VMARK   = 4'd5,
    FORM_STRESS  = 4'd6,
    FORM_INDEP   = 4'd7,
    FORM_LENGTH  = 4'd8,
    FORM_CONTROL = 4'd9,
    FORM_OTHER   = 4'd10
  } form_e;

  localparam int unsigned CuWidth = 16;
  localparam int unsigned RomAddrWidth = 7;

  // Code points of interest
  localparam logic [CuWidth-1:0] BlockFirst   = 16'h0980;
  localparam logic [CuWidth-1:0] DottedCircle = 16'h25CC;
  localparam logic [CuWidth-1:0] Zwnj         = 16'h200C;
  localparam logic [CuWidth-1:0] Zwj          = 16'h200D;
  localparam logic [CuWidth-1:0] VowelA       = 16'h0985;
  localparam logic [CuWidth-1:0] VowelE       = 16'h098F;
  localparam logic [CuWidth-1:0] SignAa       = 16'h09BE;

  // Form of each code point in the Bengali block, indexed by the low 7 bits
  localparam logic [3:0] FormRom [128] = '{
    4'd0, 4'd5, 4'd5, 4'd5, 4'd0, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd0, 4'd0, 4'd7,
    4'd7, 4'd0, 4'd0, 4'd7, 4'd7, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd0, 4'd1, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd0, 4'd0, 4'd2, 4'd10, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd0, 4'd0, 4'd4,
    4'd4, 4'd0, 4'd0, 4'd4, 4'd4, 4'd3, 4'd1, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd5,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd0, 4'd1,
    4'd7, 4'd7, 4'd5, 4'd5, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd1, 4'd1, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10
  };

  // Classification of one code unit
  typedef struct packed {
    form_e form;
    logic  in_block;
    logic  is_vowel_a;
    logic  is_vowel_e;
    logic  is_sign_aa;
  } cu_info_t;

  // Running syllable state
  typedef struct packed {
    logic  in_syllable;
    form_e previous_form;
    logic  at_second_char;
    logic  first_is_vowel_a_or_e;
    logic  previous_is_vowel_a;
  } seg_state_t;

endpackage

`default_nettype wire

// ===== src/bsb_class.sv =====
`default_nettype none

module bsb_class (
  input  logic [bsb_pkg::CuWidth-1:0] code_unit_i,
  output bsb_pkg::cu_info_t           info_o
);
  import bsb_pkg::*;

  logic in_block;

  // Bengali block is 0x0980..0x09FF: one 128-entry aligned page
  assign in_block = (code_unit_i[CuWidth-1:RomAddrWidth] == BlockFirst[CuWidth-1:RomAddrWidth]);

  // Look up the form
  always_comb begin
    info_o.in_block   = in_block;
    info_o.is_vowel_a = (code_unit_i == VowelA);
    info_o.is_vowel_e = (code_unit_i == VowelE);
    info_o.is_sign_aa = (code_unit_i == SignAa);
    if (in_block) begin
      info_o.form = form_e'(FormRom[code_unit_i[RomAddrWidth-1:0]]);
    end else if (code_unit_i == DottedCircle) begin
      info_o.form = FORM_CONS;
    end else if (code_unit_i == Zwnj || code_unit_i == Zwj) begin
      info_o.form = FORM_CONTROL;
    end else begin
      info_o.form = FORM_OTHER;
    end
  end

endmodule

`default_nettype wire

// ===== src/bsb_seg.sv =====
`default_nettype none

module bsb_seg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  bsb_pkg::cu_info_t info_i,
  input  logic              text_start_i,
  output logic              starts_unit_o,
  output logic              passthrough_o
);
  import bsb_pkg::*;

  seg_state_t state_q, state_d;
  logic       in_syl;
  logic       matra_join;
  logic       vmark_join;
  logic       joins;
  form_e      p;

  assign in_syl = state_q.in_syllable & ~text_start_i;
  assign p      = state_q.previous_form;

  // Grammar: can this form extend the open syllable
  assign matra_join = (p == FORM_CONS) || (p == FORM_NUKTA) || (p == FORM_MATRA) ||
                      (info_i.is_sign_aa && state_q.previous_is_vowel_a);
  assign vmark_join = (p == FORM_MATRA) || (p == FORM_LENGTH) || (p == FORM_INDEP) ||
                      matra_join;

  always_comb begin
    case (info_i.form)
      FORM_CONS:   joins = (p == FORM_HALANT);
      FORM_HALANT: joins = (p == FORM_NUKTA) || (p == FORM_CONS) ||
                           (state_q.at_second_char && state_q.first_is_vowel_a_or_e);
      FORM_NUKTA:  joins = (p == FORM_CONS);
      FORM_STRESS: joins = (p == FORM_VMARK) || vmark_join;
      FORM_VMARK:  joins = vmark_join;
      FORM_MATRA:  joins = matra_join;
      FORM_LENGTH: joins = (p == FORM_MATRA);
      default:     joins = 1'b0;
    endcase
  end

  // Next state and per-unit flags
  always_comb begin
    state_d             = state_q;
    state_d.in_syllable = in_syl;
    starts_unit_o       = 1'b0;
    passthrough_o       = 1'b0;
    if (in_syl && info_i.form == FORM_CONTROL) begin
      // close inclusively unless it follows a halant
      state_d.in_syllable         = (p == FORM_HALANT);
      state_d.at_second_char      = 1'b0;
      state_d.previous_is_vowel_a = info_i.is_vowel_a;
    end else if (in_syl && joins) begin
      state_d.previous_form       = info_i.form;
      state_d.at_second_char      = 1'b0;
      state_d.previous_is_vowel_a = info_i.is_vowel_a;
    end else begin
      starts_unit_o = 1'b1;
      if (!info_i.in_block) begin
        passthrough_o       = 1'b1;
        state_d.in_syllable = 1'b0;
      end else if (info_i.form == FORM_CONS || info_i.form == FORM_INDEP ||
                   info_i.form == FORM_OTHER) begin
        state_d.in_syllable           = 1'b1;
        state_d.previous_form         = info_i.form;
        state_d.at_second_char        = 1'b1;
        state_d.first_is_vowel_a_or_e = info_i.is_vowel_a | info_i.is_vowel_e;
        state_d.previous_is_vowel_a   = info_i.is_vowel_a;
      end else begin
        state_d.in_syllable = 1'b0;
      end
    end
  end

  // Commit state when the beat moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{in_syllable: 1'b0, previous_form: FORM_INVALID, at_second_char: 1'b0,
                   first_is_vowel_a_or_e: 1'b0, previous_is_vowel_a: 1'b0};
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/bengali_syllable_boundary.sv =====
`default_nettype none

// Bengali syllable boundary finder. Takes one UTF-16 code unit per beat and
// returns one result beat per code unit: whether the unit begins a new
// syllable or passthrough unit, whether it is a lone non-Bengali unit, and
// its character form. Each beat waits in the input register, where the form
// ROM lookup and the syllable state update happen, then moves to the result
// register and sits there until taken; the block sustains one code unit per
// cycle while the result is not stalled.
// text_start_i closes any open syllable before its unit is looked at.
// Reordering, matra splitting and glyph substitution are not performed.
module bengali_syllable_boundary (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bsb_pkg::CuWidth-1:0] code_unit_i,
  input  logic                        text_start_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        starts_unit_o,
  output logic                        passthrough_o,
  output logic [3:0]                  char_class_o
);
  import bsb_pkg::*;

  logic               in_valid_q;
  logic [CuWidth-1:0] code_unit_q;
  logic               text_start_q;
  logic               out_valid_q;
  logic               starts_unit_q;
  logic               passthrough_q;
  logic [3:0]         char_class_q;
  logic               accept;
  logic               advance;
  logic               starts_unit;
  logic               passthrough;
  cu_info_t           info;

  // Move a beat forward when the result register is free or being drained
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_unit_q  <= code_unit_i;
      text_start_q <= text_start_i;
    end
  end

  bsb_class u_class (
    .code_unit_i (code_unit_q),
    .info_o      (info)
  );

  bsb_seg u_seg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .info_i        (info),
    .text_start_i  (text_start_q),
    .starts_unit_o (starts_unit),
    .passthrough_o (passthrough)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      starts_unit_q <= starts_unit;
      passthrough_q <= passthrough;
      char_class_q  <= info.form;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign starts_unit_o = starts_unit_q;
  assign passthrough_o = passthrough_q;
  assign char_class_o  = char_class_q;

endmodule

`default_nettype wire

// ===== src/bsb_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module bsb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       starts_unit_o,
  input logic       passthrough_o,
  input logic [3:0] char_class_o
);
  import bsb_pkg::*;

  logic pass_form_ok;
  logic join_form_ok;

  // Forms that can come from outside the block, and forms that can extend a syllable
  assign pass_form_ok = char_class_o == FORM_CONS || char_class_o == FORM_CONTROL ||
                        char_class_o == FORM_OTHER;
  assign join_form_ok = char_class_o != FORM_INVALID && char_class_o != FORM_INDEP &&
                        char_class_o != FORM_OTHER;

  // Hold a stalled result beat
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A passthrough unit always begins a unit
  `ASSERT_IMPLIES(a_pass_starts, clk_i, rst_ni, out_valid_o && passthrough_o, starts_unit_o)

  // Passthrough units come from outside the block: consonant, control or other only
  `ASSERT_IMPLIES(a_pass_form, clk_i, rst_ni, out_valid_o && passthrough_o, pass_form_ok)

  // Invalid, independent vowel and other never extend a syllable
  `ASSERT_IMPLIES(a_join_form, clk_i, rst_ni, out_valid_o && !starts_unit_o, join_form_ok)

endmodule

bind bengali_syllable_boundary bsb_checker u_bsb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .starts_unit_o (starts_unit_o),
  .passthrough_o (passthrough_o),
  .char_class_o  (char_class_o)
);

`default_nettype wire

// ===== test/tb.sv =====
module tb;
  import bsb_pkg::*;

  localparam logic [15:0] BlockLast = 16'h09FF;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned ItemsPerPhase = 400;
  localparam int unsigned HoldOffCycles = 80;

  // One result beat as the block reports it
  typedef struct packed {
    logic  starts;
    logic  pass;
    form_e form;
  } boundary_t;

  // A result beat still owed by the block, with the code unit that caused it
  typedef struct packed {
    logic [15:0] cu;
    boundary_t   want;
  } owed_t;

  // One row of the directed stimulus; fixed holds a hand-typed result
  typedef struct packed {
    logic [15:0] cu;
    logic        fresh;
    logic        fixed;
    boundary_t   want;
  } dir_row_t;

  localparam boundary_t NoWant = '{1'b0, 1'b0, FORM_INVALID};

  localparam dir_row_t DirRows [25] = '{
    '{16'h0000, 1'b1, 1'b1, '{1'b1, 1'b1, FORM_OTHER}},
    '{16'hFFFF, 1'b0, 1'b1, '{1'b1, 1'b1, FORM_OTHER}},
    '{16'h7FFF, 1'b0, 1'b1, '{1'b1, 1'b1, FORM_OTHER}},
    '{16'h8000, 1'b0, 1'b1, '{1'b1, 1'b1, FORM_OTHER}},
    '{16'h0980, 1'b0, 1'b1, '{1'b1, 1'b0, FORM_INVALID}},
    '{16'h09FF, 1'b0, 1'b1, '{1'b1, 1'b0, FORM_OTHER}},
    '{16'h0995, 1'b0, 1'b0, NoWant},
    '{16'h09BC, 1'b0, 1'b0, NoWant},
    '{16'h09CD, 1'b0, 1'b0, NoWant},
    '{16'h200D, 1'b0, 1'b0, NoWant},
    '{16'h0995, 1'b0, 1'b0, NoWant},
    '{16'h09BF, 1'b0, 1'b0, NoWant},
    '{16'h09D7, 1'b0, 1'b0, NoWant},
    '{16'h200C, 1'b0, 1'b0, NoWant},
    '{16'h0985, 1'b0, 1'b0, NoWant},
    '{16'h09BE, 1'b0, 1'b0, NoWant},
    '{16'h098F, 1'b0, 1'b0, NoWant},
    '{16'h09CD, 1'b0, 1'b0, NoWant},
    '{16'h25CC, 1'b0, 1'b0, NoWant},
    '{16'h25CC, 1'b1, 1'b1, '{1'b1, 1'b1, FORM_CONS}},
    '{16'h200C, 1'b0, 1'b1, '{1'b1, 1'b1, FORM_CONTROL}},
    '{16'h0981, 1'b0, 1'b1, '{1'b1, 1'b0, FORM_VMARK}},
    '{16'h09CD, 1'b0, 1'b1, '{1'b1, 1'b0, FORM_HALANT}},
    '{16'h0995, 1'b0, 1'b1, '{1'b1, 1'b0, FORM_CONS}},
    '{16'h0995, 1'b1, 1'b1, '{1'b1, 1'b0, FORM_CONS}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] code_unit_i = '0;
  logic        text_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        starts_unit_o;
  logic        passthrough_o;
  logic [3:0]  char_class_o;

  // Predicted segmentation state
  bit    syl_open;
  form_e last_form = FORM_INVALID;
  bit    second_pending;
  bit    opened_a_or_e;
  bit    last_was_a;

  owed_t       owed_q[$];
  int unsigned units_sent;
  int unsigned restarts_sent;
  int unsigned beats_checked;
  int unsigned starts_seen;
  int unsigned pass_seen;
  int unsigned bad_beats;
  int unsigned quiet_cycles;
  int unsigned send_pct;
  int unsigned recv_pct;
  int unsigned hold_left;
  bit          hold_asked;
  bit          hold_begun;
  bit [15:0]   forms_seen;

  bengali_syllable_boundary dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_unit_i  (code_unit_i),
    .text_start_i (text_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .starts_unit_o(starts_unit_o),
    .passthrough_o(passthrough_o),
    .char_class_o (char_class_o)
  );

  always #1 clk_i = ~clk_i;

  // Form of a code point in the Bengali block, by its low 7 bits
  function automatic form_e block_form(logic [6:0] i);
    if ((i >= 7'h01 && i <= 7'h03) || i == 7'h57 || i == 7'h62 || i == 7'h63)
      return FORM_VMARK;
    if ((i >= 7'h05 && i <= 7'h0C) || i == 7'h0F || i == 7'h10 || i == 7'h13 ||
        i == 7'h14 || i == 7'h60 || i == 7'h61)
      return FORM_INDEP;
    if (i == 7'h3C) return FORM_NUKTA;
    if (i == 7'h4D) return FORM_HALANT;
    if ((i >= 7'h3E && i <= 7'h44) || i == 7'h47 || i == 7'h48 || i == 7'h4B ||
        i == 7'h4C)
      return FORM_MATRA;
    if (i == 7'h3D || (i >= 7'h64 && i <= 7'h6F) || i >= 7'h72) return FORM_OTHER;
    if ((i >= 7'h15 && i <= 7'h28) || (i >= 7'h2A && i <= 7'h30) || i == 7'h32 ||
        (i >= 7'h36 && i <= 7'h39) || i == 7'h4E || i == 7'h5C || i == 7'h5D ||
        i == 7'h5F || i == 7'h70 || i == 7'h71)
      return FORM_CONS;
    return FORM_INVALID;
  endfunction

  function automatic bit in_bengali(logic [15:0] cu);
    return cu >= BlockFirst && cu <= BlockLast;
  endfunction

  function automatic form_e form_of(logic [15:0] cu);
    if (in_bengali(cu)) return block_form(cu[6:0]);
    if (cu == DottedCircle) return FORM_CONS;
    if (cu == Zwnj || cu == Zwj) return FORM_CONTROL;
    return FORM_OTHER;
  endfunction

  function automatic bit matra_fits(logic [15:0] cu);
    return last_form == FORM_CONS || last_form == FORM_NUKTA || last_form == FORM_MATRA ||
           (cu == SignAa && last_was_a);
  endfunction

  function automatic bit vmark_fits(logic [15:0] cu);
    return last_form == FORM_MATRA || last_form == FORM_LENGTH ||
           last_form == FORM_INDEP || matra_fits(cu);
  endfunction

  // Decide whether a unit extends the open syllable
  function automatic bit unit_joins(form_e f, logic [15:0] cu);
    case (f)
      FORM_CONS:   return last_form == FORM_HALANT;
      FORM_HALANT: return last_form == FORM_NUKTA || last_form == FORM_CONS ||
                          (second_pending && opened_a_or_e);
      FORM_NUKTA:  return last_form == FORM_CONS;
      FORM_STRESS: return last_form == FORM_VMARK || vmark_fits(cu);
      FORM_VMARK:  return vmark_fits(cu);
      FORM_MATRA:  return matra_fits(cu);
      FORM_LENGTH: return last_form == FORM_MATRA;
      default:     return 1'b0;
    endcase
  endfunction

  // Advance the predicted state by one code unit and return its result beat
  function automatic boundary_t next_boundary(logic [15:0] cu, logic fresh);
    boundary_t r;
    form_e     f;
    f = form_of(cu);
    r = '{1'b0, 1'b0, f};
    if (fresh) syl_open = 1'b0;
    if (syl_open && f == FORM_CONTROL) begin
      if (last_form != FORM_HALANT) syl_open = 1'b0;
      second_pending = 1'b0;
      last_was_a = (cu == VowelA);
    end else if (syl_open && unit_joins(f, cu)) begin
      last_form = f;
      second_pending = 1'b0;
      last_was_a = (cu == VowelA);
    end else begin
      r.starts = 1'b1;
      if (!in_bengali(cu)) begin
        r.pass = 1'b1;
        syl_open = 1'b0;
      end else if (f == FORM_CONS || f == FORM_INDEP || f == FORM_OTHER) begin
        syl_open = 1'b1;
        last_form = f;
        second_pending = 1'b1;
        opened_a_or_e = (cu == VowelA || cu == VowelE);
        last_was_a = (cu == VowelA);
      end else begin
        syl_open = 1'b0;
      end
    end
    return r;
  endfunction

  // Random code point in the block with the given form
  function automatic logic [15:0] pick_form(form_e f);
    logic [6:0] i;
    i = 7'($urandom_range(127));
    while (block_form(i) != f) i = 7'($urandom_range(127));
    return BlockFirst | 16'(i);
  endfunction

  function automatic logic [15:0] pick_cons();
    return ($urandom_range(7) == 0) ? DottedCircle : pick_form(FORM_CONS);
  endfunction

  function automatic logic [15:0] pick_joiner();
    return $urandom_range(1) ? Zwj : Zwnj;
  endfunction

  // Offer one beat, hold it until taken, then record what the block owes
  task automatic send_beat(logic [15:0] cu, logic fresh, logic fixed, boundary_t want);
    boundary_t guess;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    code_unit_i = cu;
    text_start_i = fresh;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    guess = next_boundary(cu, fresh);
    owed_q.push_back('{cu, fixed ? want : guess});
    units_sent++;
    if (fresh) restarts_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_unit(logic [15:0] cu);
    send_beat(cu, $urandom_range(39) == 0, 1'b0, NoWant);
  endtask

  // Mostly well-formed syllables with random content, some noise
  task automatic send_syllable();
    int unsigned kind;
    int unsigned links;
    kind = $urandom_range(15);
    if (kind < 7) begin
      // consonant cluster with optional nukta, conjuncts and signs
      send_unit(pick_cons());
      if ($urandom_range(3) == 0) send_unit(pick_form(FORM_NUKTA));
      links = $urandom_range(2);
      repeat (links) begin
        send_unit(pick_form(FORM_HALANT));
        if ($urandom_range(4) == 0) send_unit(pick_joiner());
        send_unit(pick_cons());
      end
      case ($urandom_range(5))
        0: send_unit(pick_form(FORM_HALANT));
        1: begin
          send_unit(pick_form(FORM_MATRA));
          if ($urandom_range(1)) send_unit(pick_form(FORM_VMARK));
        end
        2: begin
          send_unit(pick_form(FORM_MATRA));
          send_unit(pick_form(FORM_MATRA));
        end
        3: send_unit(pick_joiner());
        4: send_unit(pick_form(FORM_VMARK));
        default: ;
      endcase
    end else if (kind < 10) begin
      // independent vowels, including the vowel A and E exceptions
      case ($urandom_range(3))
        0: begin
          send_unit(VowelA);
          send_unit(SignAa);
        end
        1: begin
          send_unit($urandom_range(1) ? VowelA : VowelE);
          send_unit(pick_form(FORM_HALANT));
          if ($urandom_range(1)) send_unit(pick_cons());
        end
        2: begin
          send_unit(pick_form(FORM_INDEP));
          send_unit(pick_form(FORM_VMARK));
        end
        default: send_unit(pick_form(FORM_INDEP));
      endcase
    end else if (kind < 12) begin
      // text outside the block, or block symbols that open a syllable
      case ($urandom_range(2))
        0: send_unit(16'($urandom_range(32, 126)));
        1: send_unit(pick_form(FORM_OTHER));
        default: send_unit(pick_joiner());
      endcase
    end else if (kind < 14) begin
      // anything from the block, stray marks included
      send_unit(BlockFirst | 16'($urandom_range(127)));
    end else begin
      send_unit(16'($urandom_range(65535)));
    end
  endtask

  // Receiver stalls: a long hold-off when asked, else random
  always @(negedge clk_i) begin
    if (hold_asked && !hold_begun) begin
      hold_left = HoldOffCycles;
      hold_begun = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = recv_pct != 0 && $urandom_range(99) < recv_pct;
    end
  end

  // Compare each result beat with the oldest owed one
  always @(posedge clk_i) begin
    owed_t o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_q.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("ERROR: unexpected result beat starts=%0d pass=%0d class=%0d",
                   starts_unit_o, passthrough_o, char_class_o);
      end else begin
        o = owed_q.pop_front();
        beats_checked++;
        if (starts_unit_o) starts_seen++;
        if (passthrough_o) pass_seen++;
        forms_seen[char_class_o] = 1'b1;
        if (starts_unit_o !== o.want.starts || passthrough_o !== o.want.pass ||
            char_class_o !== o.want.form) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("ERROR: cu %h expected starts=%0d pass=%0d class=%0d, got %0d %0d %0d",
                     o.cu, o.want.starts, o.want.pass, o.want.form,
                     starts_unit_o, passthrough_o, char_class_o);
        end
      end
    end
  end

  // End the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("ERROR: no beat moved for %0d cycles", QuietLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned goal;
    bit          pressed;
    pressed = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed rows with no idling
    foreach (DirRows[k])
      send_beat(DirRows[k].cu, DirRows[k].fresh, DirRows[k].fixed, DirRows[k].want);

    // Random text under each idling mix
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 52; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 52; end
        default: begin send_pct = 7; recv_pct = 7; end
      endcase
      goal = units_sent + ItemsPerPhase;
      while (units_sent < goal) begin
        if (phase == 0 && !pressed && units_sent + 300 > goal) begin
          hold_asked = 1'b1;
          pressed = 1'b1;
        end
        send_syllable();
      end
    end
    in_valid_i = 1'b0;

    // Drain the owed results, then watch for strays
    while (owed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d code units (%0d text restarts); checked %0d results.",
             units_sent, restarts_sent, beats_checked);
    $display("Saw %0d unit starts, %0d passthroughs, %0d distinct forms; %0d mismatches.",
             starts_seen, pass_seen, $countones(forms_seen), bad_beats);
    if (bad_beats == 0 && owed_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
